[hw/rtl/wcsp_pkg.sv]
// Shared types, step codes, result codes and the control program for the WAV chunk parser.
`timescale 1ns / 1ps

package wcsp_pkg;

  // Sequencer step addresses
  localparam logic [3:0] STEP_PRE  = 4'd0;
  localparam logic [3:0] STEP_HDR  = 4'd1;
  localparam logic [3:0] STEP_FMT  = 4'd2;
  localparam logic [3:0] STEP_SKIP = 4'd3;
  localparam logic [3:0] STEP_DATA = 4'd4;
  localparam logic [3:0] STEP_DONE = 4'd5;
  localparam logic [3:0] STEP_DIV  = 4'd6;
  localparam logic [3:0] STEP_MUL  = 4'd7;
  localparam logic [3:0] STEP_CHK  = 4'd8;

  // Result kinds
  localparam logic [1:0] KIND_INFO   = 2'd0;
  localparam logic [1:0] KIND_SAMPLE = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_NO_FMT     = 2'd0;
  localparam logic [1:0] ERR_BITS       = 2'd1;
  localparam logic [1:0] ERR_ZERO_SHAPE = 2'd2;

  // Chunk tags, little-endian as they arrive
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // Fixed byte positions
  localparam logic [3:0]  PRE_LAST      = 4'd11;
  localparam logic [3:0]  HDR_LAST      = 4'd7;
  localparam logic [3:0]  FMT_CHANNELS  = 4'd3;
  localparam logic [3:0]  FMT_ALIGN     = 4'd13;
  localparam logic [3:0]  FMT_BITS      = 4'd15;
  localparam logic [15:0] BITS_REQUIRED = 16'd16;
  localparam logic [31:0] FMT_BODY_LEN  = 32'd16;

  // One control word per step
  typedef struct packed {
    logic       take_byte;
    logic [3:0] op;
    logic [3:0] jmp;
  } ctl_t;

  // Datapath operations selected by a control word
  localparam logic [3:0] OPW_PRE  = 4'd0;
  localparam logic [3:0] OPW_HDR  = 4'd1;
  localparam logic [3:0] OPW_FMT  = 4'd2;
  localparam logic [3:0] OPW_SKIP = 4'd3;
  localparam logic [3:0] OPW_DATA = 4'd4;
  localparam logic [3:0] OPW_IDLE = 4'd5;
  localparam logic [3:0] OPW_DIV  = 4'd6;
  localparam logic [3:0] OPW_MUL  = 4'd7;
  localparam logic [3:0] OPW_CHK  = 4'd8;

  // Divider handshake status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Control program
  function automatic ctl_t ctl_rom(input logic [3:0] pc);
    ctl_t w;
    case (pc)
      STEP_PRE:  w = '{take_byte: 1'b1, op: OPW_PRE,  jmp: STEP_HDR};
      STEP_HDR:  w = '{take_byte: 1'b1, op: OPW_HDR,  jmp: STEP_FMT};
      STEP_FMT:  w = '{take_byte: 1'b1, op: OPW_FMT,  jmp: STEP_SKIP};
      STEP_SKIP: w = '{take_byte: 1'b1, op: OPW_SKIP, jmp: STEP_HDR};
      STEP_DATA: w = '{take_byte: 1'b1, op: OPW_DATA, jmp: STEP_DONE};
      STEP_DONE: w = '{take_byte: 1'b1, op: OPW_IDLE, jmp: STEP_DONE};
      STEP_DIV:  w = '{take_byte: 1'b0, op: OPW_DIV,  jmp: STEP_MUL};
      STEP_MUL:  w = '{take_byte: 1'b0, op: OPW_MUL,  jmp: STEP_CHK};
      STEP_CHK:  w = '{take_byte: 1'b0, op: OPW_CHK,  jmp: STEP_DATA};
      default:   w = '{take_byte: 1'b1, op: OPW_IDLE, jmp: STEP_DONE};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/wav_chunk_stream_parser_core.sv]
// Top level of the WAV chunk parser: step sequencer, byte datapath and result register.
// Takes a WAV file one byte per word on the in_ channel and returns format info, 16-bit
// samples and errors on the out_ channel. Bytes are taken at one per cycle everywhere
// except at a data chunk header that raises no error: its last byte starts a bit-serial
// divide (data length by block alignment), then one multiply step and one step that
// posts the info word, and in_stall stays high through all of these steps. A byte
// is also held off while a finished word waits in the output register and out_stall is
// high. After an error, or once all samples are out, every byte is taken and dropped.
`timescale 1ns / 1ps

module wav_chunk_stream_parser_core
  import wcsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_kind,
  output logic signed [15:0] out_sample,
  output logic [15:0]        out_channels,
  output logic [31:0]        out_frame_count,
  output logic [1:0]         out_error_code
);

  ctl_t        ctl;
  logic [3:0]  pc_r, pc_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [32:0] cnt_r, cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [15:0] ch_r, ch_nxt;
  logic [15:0] al_r, al_nxt;
  logic [47:0] sbl_r, sbl_nxt;
  logic [7:0]  low_r, low_nxt;
  logic        half_r, half_nxt;
  logic        fmt_seen_r, fmt_seen_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] smp_r, smp_nxt;
  logic [15:0] och_r, och_nxt;
  logic [31:0] frm_r, frm_nxt;
  logic [1:0]  err_r, err_nxt;

  logic        out_free;
  logic        in_fire;
  logic        div_start;
  logic [31:0] quot;
  div_stat_t   div_stat;
  logic [31:0] len_new;
  logic [15:0] word16;
  logic [32:0] skip_n;
  logic [32:0] fmt_rest;

  assign ctl      = ctl_rom(pc_r);
  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = ~ctl.take_byte | ~out_free;
  assign in_fire  = in_valid & ~in_stall;

  // Length as it stands once the last header byte lands
  assign len_new = {in_byte, len_r[23:0]};
  assign word16  = {in_byte, low_r};
  assign skip_n  = {1'b0, len_new} + {32'd0, len_new[0]};
  assign fmt_rest = (len_r > FMT_BODY_LEN)
                  ? ({1'b0, len_r - FMT_BODY_LEN} + {32'd0, len_r[0]}) : '0;

  wcsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (len_new),
    .divisor  (al_r),
    .quotient (quot),
    .stat     (div_stat)
  );

  // Datapath driven by the current control word
  always_comb begin
    pc_nxt       = pc_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    tag_nxt      = tag_r;
    len_nxt      = len_r;
    ch_nxt       = ch_r;
    al_nxt       = al_r;
    sbl_nxt      = sbl_r;
    low_nxt      = low_r;
    half_nxt     = half_r;
    fmt_seen_nxt = fmt_seen_r;
    div_start    = 1'b0;

    out_valid_nxt = out_valid_r & out_stall;
    kind_nxt      = kind_r;
    smp_nxt       = smp_r;
    och_nxt       = och_r;
    frm_nxt       = frm_r;
    err_nxt       = err_r;

    case (ctl.op)
      OPW_PRE: begin
        if (in_fire) begin
          idx_nxt = idx_r + 4'd1;
          if (idx_r == PRE_LAST) begin
            idx_nxt = '0;
            pc_nxt  = ctl.jmp;
          end
        end
      end

      OPW_HDR: begin
        if (in_fire) begin
          if (!idx_r[2]) tag_nxt[8*idx_r[1:0] +: 8] = in_byte;
          else           len_nxt[8*idx_r[1:0] +: 8] = in_byte;
          idx_nxt = idx_r + 4'd1;
          if (idx_r == HDR_LAST) begin
            idx_nxt = '0;
            if (tag_r == TAG_FMT) begin
              pc_nxt = ctl.jmp;
            end else if (tag_r == TAG_DATA) begin
              if (!fmt_seen_r) begin
                out_valid_nxt = 1'b1;
                kind_nxt = KIND_ERROR; smp_nxt = '0; och_nxt = '0; frm_nxt = '0;
                err_nxt  = ERR_NO_FMT;
                pc_nxt   = STEP_DONE;
              end else if (ch_r == '0 || al_r == '0) begin
                out_valid_nxt = 1'b1;
                kind_nxt = KIND_ERROR; smp_nxt = '0; och_nxt = '0; frm_nxt = '0;
                err_nxt  = ERR_ZERO_SHAPE;
                pc_nxt   = STEP_DONE;
              end else begin
                div_start = 1'b1;
                pc_nxt    = STEP_DIV;
              end
            end else if (skip_n == '0) begin
              pc_nxt = STEP_HDR;
            end else begin
              cnt_nxt = skip_n;
              pc_nxt  = STEP_SKIP;
            end
          end
        end
      end

      OPW_FMT: begin
        if (in_fire) begin
          idx_nxt = idx_r + 4'd1;
          if (!idx_r[0]) begin
            low_nxt = in_byte;
          end else if (idx_r == FMT_CHANNELS) begin
            ch_nxt = word16;
          end else if (idx_r == FMT_ALIGN) begin
            al_nxt = word16;
          end else if (idx_r == FMT_BITS) begin
            idx_nxt = '0;
            if (word16 != BITS_REQUIRED) begin
              out_valid_nxt = 1'b1;
              kind_nxt = KIND_ERROR; smp_nxt = '0; och_nxt = '0; frm_nxt = '0;
              err_nxt  = ERR_BITS;
              pc_nxt   = STEP_DONE;
            end else begin
              fmt_seen_nxt = 1'b1;
              if (fmt_rest == '0) begin
                pc_nxt = STEP_HDR;
              end else begin
                cnt_nxt = fmt_rest;
                pc_nxt  = ctl.jmp;
              end
            end
          end
        end
      end

      OPW_SKIP: begin
        if (in_fire) begin
          cnt_nxt = cnt_r - 33'd1;
          if (cnt_r == 33'd1) begin
            idx_nxt = '0;
            pc_nxt  = ctl.jmp;
          end
        end
      end

      OPW_DATA: begin
        if (in_fire) begin
          if (!half_r) begin
            low_nxt  = in_byte;
            half_nxt = 1'b1;
          end else begin
            half_nxt      = 1'b0;
            out_valid_nxt = 1'b1;
            kind_nxt = KIND_SAMPLE; smp_nxt = word16; och_nxt = '0; frm_nxt = '0;
            err_nxt  = '0;
            sbl_nxt  = sbl_r - 48'd1;
            if (sbl_r == 48'd1) pc_nxt = ctl.jmp;
          end
        end
      end

      OPW_DIV: begin
        if (div_stat.done && !div_stat.busy) pc_nxt = ctl.jmp;
      end

      // Sample count = frames times channels, registered before use
      OPW_MUL: begin
        sbl_nxt = {16'd0, quot} * {32'd0, ch_r};
        pc_nxt  = ctl.jmp;
      end

      OPW_CHK: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          kind_nxt = KIND_INFO; smp_nxt = '0; och_nxt = ch_r; frm_nxt = quot;
          err_nxt  = '0;
          half_nxt = 1'b0;
          pc_nxt   = (sbl_r == '0) ? STEP_DONE : ctl.jmp;
        end
      end

      default: begin
        // done or faulted: bytes are taken and dropped
      end
    endcase
  end

  // Control state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= STEP_PRE;
      idx_r       <= '0;
      cnt_r       <= '0;
      tag_r       <= '0;
      len_r       <= '0;
      ch_r        <= '0;
      al_r        <= '0;
      sbl_r       <= '0;
      low_r       <= '0;
      half_r      <= 1'b0;
      fmt_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      tag_r       <= tag_nxt;
      len_r       <= len_nxt;
      ch_r        <= ch_nxt;
      al_r        <= al_nxt;
      sbl_r       <= sbl_nxt;
      low_r       <= low_nxt;
      half_r      <= half_nxt;
      fmt_seen_r  <= fmt_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r <= kind_nxt;
    smp_r  <= smp_nxt;
    och_r  <= och_nxt;
    frm_r  <= frm_nxt;
    err_r  <= err_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = kind_r;
  assign out_sample      = smp_r;
  assign out_channels    = och_r;
  assign out_frame_count = frm_r;
  assign out_error_code  = err_r;

endmodule

[hw/rtl/wcsp_div.sv]
// Restoring divider, one quotient bit per cycle: 32-bit dividend by 16-bit divisor.
`timescale 1ns / 1ps

module wcsp_div
  import wcsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [15:0] divisor,
  output logic [31:0] quotient,
  output div_stat_t   stat
);

  logic [31:0] q_r, q_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] d_r, d_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [16:0] trial;
  logic [16:0] diff;
  logic        ge;

  // One trial subtraction per cycle
  assign trial = {rem_r, q_r[31]};
  assign ge    = trial >= {1'b0, d_r};
  assign diff  = trial - {1'b0, d_r};

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
      cnt_nxt  = '1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      q_nxt   = {q_r[30:0], ge};
      rem_nxt = ge ? diff[15:0] : trial[15:0];
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[tb/sv/wav_chunk_stream_parser_core_test.sv]
// Self-checking testbench for the WAV chunk parser: builds WAV byte streams and checks each word.
`timescale 1ns / 1ps

module wav_chunk_stream_parser_core_test
  import wcsp_pkg::*;
();

  // How the stream of one run ends
  localparam int SCEN_NO_FMT     = 0;
  localparam int SCEN_BAD_BITS   = 1;
  localparam int SCEN_ZERO_SHAPE = 2;
  localparam int SCEN_NO_SAMPLES = 3;
  localparam int SCEN_AUDIO      = 4;
  localparam int SCEN_LAST       = 9;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 64;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample;
    logic [15:0]        channels;
    logic [31:0]        frame_count;
    logic [1:0]         error_code;
  } parse_word_t;

  // Parser state mirror plus the queue of words it predicts
  class wav_parse_tracker;
    logic [3:0]  phase;
    logic [32:0] bytes_left;
    logic [31:0] tag;
    logic [31:0] length;
    logic [15:0] chans;
    logic [15:0] align;
    logic [47:0] samples_left;
    logic [7:0]  low;
    bit          fault;
    bit          fmt_seen;
    bit          half;
    parse_word_t expected_words[$];
    int          failures;

    function new();
      phase = STEP_PRE;
      bytes_left = 33'd12;
      tag = '0;
      length = '0;
      chans = '0;
      align = '0;
      samples_left = '0;
      low = '0;
      fault = 1'b0;
      fmt_seen = 1'b0;
      half = 1'b0;
      failures = 0;
    endfunction

    function void post(logic [1:0] kind, logic [15:0] smp, logic [15:0] ch,
                       logic [31:0] frames, logic [1:0] code);
      parse_word_t w;
      w.kind = kind;
      w.sample = smp;
      w.channels = ch;
      w.frame_count = frames;
      w.error_code = code;
      expected_words.push_back(w);
    endfunction

    function void raise_fault(logic [1:0] code);
      fault = 1'b1;
      phase = STEP_DONE;
      post(KIND_ERROR, '0, '0, '0, code);
    endfunction

    // Zero bytes to skip means the next chunk header starts right away
    function void to_skip(logic [32:0] n);
      if (n == 0) begin
        phase = STEP_HDR;
        bytes_left = 33'd8;
      end else begin
        phase = STEP_SKIP;
        bytes_left = n;
      end
    endfunction

    // Advance the mirror by one accepted byte
    function void take_byte(logic [7:0] b);
      int k;
      logic [15:0] v;
      logic [31:0] frames;
      logic [32:0] rest;
      if (fault) return;
      case (phase)
        STEP_PRE, STEP_SKIP: begin
          if (bytes_left != 0) bytes_left--;
          if (bytes_left == 0) to_skip('0);
        end
        STEP_HDR: begin
          k = 8 - bytes_left[3:0];
          if (k < 4) tag[8*k +: 8] = b;
          else length[8*(k-4) +: 8] = b;
          bytes_left--;
          if (bytes_left == 0) begin
            if (tag == TAG_FMT) begin
              phase = STEP_FMT;
              bytes_left = 33'd16;
            end else if (tag == TAG_DATA) begin
              if (!fmt_seen) raise_fault(ERR_NO_FMT);
              else if (chans == 0 || align == 0) raise_fault(ERR_ZERO_SHAPE);
              else begin
                frames = length / align;
                samples_left = {16'd0, frames} * {32'd0, chans};
                half = 1'b0;
                phase = (samples_left == 0) ? STEP_DONE : STEP_DATA;
                post(KIND_INFO, '0, chans, frames, '0);
              end
            end else begin
              // odd-length chunks carry one pad byte
              to_skip({1'b0, length} + length[0]);
            end
          end
        end
        STEP_FMT: begin
          k = 16 - bytes_left[4:0];
          bytes_left--;
          if (k % 2 == 0) low = b;
          else begin
            v = {b, low};
            if (k == FMT_CHANNELS) chans = v;
            else if (k == FMT_ALIGN) align = v;
            else if (k == FMT_BITS) begin
              if (v != BITS_REQUIRED) raise_fault(ERR_BITS);
              else begin
                fmt_seen = 1'b1;
                // a short fmt leaves nothing to skip
                rest = (length > FMT_BODY_LEN) ?
                       {1'b0, length - FMT_BODY_LEN} + length[0] : '0;
                to_skip(rest);
              end
            end
          end
        end
        STEP_DATA: begin
          if (!half) begin
            low = b;
            half = 1'b1;
          end else begin
            half = 1'b0;
            post(KIND_SAMPLE, {b, low}, '0, '0, '0);
            samples_left--;
            if (samples_left == 0) phase = STEP_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void compare_word(logic [1:0] kind, logic signed [15:0] smp,
                               logic [15:0] ch, logic [31:0] frames,
                               logic [1:0] code);
      parse_word_t w;
      if (expected_words.size() == 0) begin
        $error("word with none pending: kind %0d", kind);
        failures++;
        return;
      end
      w = expected_words.pop_front();
      check_field("kind", w.kind, kind);
      check_field("sample", w.sample, smp);
      check_field("channels", w.channels, ch);
      check_field("frame_count", w.frame_count, frames);
      check_field("error_code", w.error_code, code);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_byte;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_kind;
  logic signed [15:0] out_sample;
  logic [15:0]        out_channels;
  logic [31:0]        out_frame_count;
  logic [1:0]         out_error_code;

  wav_parse_tracker book;
  bit               calm;
  int               stall_left = 0;
  int unsigned      cycle_count = 0;

  wav_chunk_stream_parser_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_sample      (out_sample),
    .out_channels    (out_channels),
    .out_frame_count (out_frame_count),
    .out_error_code  (out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wav_chunk_stream_parser_core_test NOT OK");
      $finish;
    end
  end

  // Result side: check accepted words, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.compare_word(out_kind, out_sample, out_channels, out_frame_count, out_error_code);
    if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0)
      stall_left = $urandom_range(1, 12);
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // One byte word, sometimes with a random gap ahead of it while not calm
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    book.take_byte(b);
  endtask

  task automatic send_filler(input longint n);
    for (longint i = 0; i < n; i++) send_byte(8'($urandom()));
  endtask

  task automatic send_head(input logic [31:0] tag, input logic [31:0] len);
    for (int i = 0; i < 4; i++) send_byte(tag[8*i +: 8]);
    for (int i = 0; i < 4; i++) send_byte(len[8*i +: 8]);
  endtask

  // Tags that are neither fmt nor data, often one bit away from them
  function automatic logic [31:0] junk_tag();
    logic [31:0] t;
    do begin
      if ($urandom_range(0, 1)) t = $urandom();
      else t = ($urandom_range(0, 1) ? TAG_FMT : TAG_DATA) ^ (32'd1 << $urandom_range(0, 31));
    end while (t == TAG_FMT || t == TAG_DATA);
    return t;
  endfunction

  task automatic send_junk(input logic [31:0] len);
    send_head(junk_tag(), len);
    send_filler(longint'(len) + len[0]);
  endtask

  task automatic send_fmt(input logic [31:0] len, input logic [15:0] ch,
                          input logic [15:0] align, input logic [15:0] bits);
    logic [7:0] body [0:15];
    for (int i = 0; i < 16; i++) body[i] = 8'($urandom());
    body[FMT_CHANNELS - 1] = ch[7:0];
    body[FMT_CHANNELS]     = ch[15:8];
    body[FMT_ALIGN - 1]    = align[7:0];
    body[FMT_ALIGN]        = align[15:8];
    body[FMT_BITS - 1]     = bits[7:0];
    body[FMT_BITS]         = bits[15:8];
    send_head(TAG_FMT, len);
    for (int i = 0; i < 16; i++) send_byte(body[i]);
    if (len > FMT_BODY_LEN) send_filler(longint'(len - FMT_BODY_LEN) + len[0]);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.expected_words.size() != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int scen;
    int walk;
    int quarter;
    logic [31:0] len;
    logic [15:0] ch;
    logic [15:0] align;
    logic [15:0] bits;
    longint frames;
    longint nbytes;

    book = new();
    calm = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    scen = $urandom_range(SCEN_NO_FMT, SCEN_LAST);

    // preamble, extremes first
    send_byte(8'h00);
    send_byte(8'hFF);
    send_filler(10);

    // directed chunks: empty, odd with pad, short fmt, odd fmt with pad
    send_junk(32'd0);
    send_junk(32'd3);
    if (scen != SCEN_NO_FMT) begin
      send_fmt(32'd10, 16'd2, 16'd4, BITS_REQUIRED);
      send_fmt(32'd19, 16'd1, 16'd2, BITS_REQUIRED);
    end

    // random chunk walk, longer when the run ends early
    walk = (scen >= SCEN_AUDIO) ? $urandom_range(2, 5) : $urandom_range(8, 14);
    for (int i = 0; i < walk; i++) begin
      if (scen == SCEN_NO_FMT || $urandom_range(0, 2) != 0)
        send_junk($urandom_range(0, 60));
      else
        send_fmt($urandom_range(0, 40), $urandom_range(1, 4), $urandom_range(1, 16),
                 BITS_REQUIRED);
    end

    case (scen)
      SCEN_NO_FMT: send_head(TAG_DATA, $urandom());
      SCEN_BAD_BITS: begin
        bits = 16'($urandom());
        if ($urandom_range(0, 2) == 0) bits = BITS_REQUIRED ^ (16'd1 << $urandom_range(0, 15));
        if (bits == BITS_REQUIRED) bits = 16'hFFFF;
        send_fmt($urandom_range(0, 24), $urandom_range(1, 4), $urandom_range(1, 16), bits);
      end
      SCEN_ZERO_SHAPE: begin
        ch = $urandom_range(1, 65535);
        align = $urandom_range(1, 65535);
        case ($urandom_range(0, 2))
          0: ch = '0;
          1: align = '0;
          default: begin
            ch = '0;
            align = '0;
          end
        endcase
        send_fmt(FMT_BODY_LEN, ch, align, BITS_REQUIRED);
        send_head(TAG_DATA, $urandom());
      end
      SCEN_NO_SAMPLES: begin
        align = $urandom_range(2, 64);
        send_fmt(FMT_BODY_LEN, $urandom_range(1, 4), align, BITS_REQUIRED);
        send_head(TAG_DATA, $urandom_range(0, align - 1));
      end
      default: begin
        ch = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 4));
        align = ($urandom_range(0, 5) == 0) ? 16'hFFFF : 16'($urandom_range(1, 16));
        nbytes = 2 * $urandom_range(180, 240);
        if (ch == 16'hFFFF || $urandom_range(0, 3) == 0) begin
          // long data chunk: the run stops partway through it
          len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'($urandom());
          if (len < align) len = 32'hFFFF_FFFF;
        end else begin
          frames = nbytes / 2 / ch;
          len = 32'(frames * align + $urandom_range(0, align - 1));
        end
        send_fmt($urandom_range(12, 24), ch, align, BITS_REQUIRED);
        send_head(TAG_DATA, len);
      end
    endcase

    // hold the sender until the info or error word is out
    wait_drained();

    if (scen >= SCEN_AUDIO) begin
      frames = longint'(len / align) * ch * 2;
      if (frames < nbytes) nbytes = frames;
      // full-scale samples first
      send_byte(8'h00); send_byte(8'h80);
      send_byte(8'hFF); send_byte(8'h7F);
      send_byte(8'h00); send_byte(8'h00);
      send_byte(8'hFF); send_byte(8'hFF);
      quarter = int'(nbytes / 4);
      send_filler(nbytes - 8 - quarter);
      calm = 1'b1;
      send_filler(quarter);
    end

    // trailing bytes, ignored once the parser is done or faulted
    calm = 1'b1;
    send_filler(24);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (book.failures == 0 && book.expected_words.size() == 0)
      $display("wav_chunk_stream_parser_core_test OK");
    else
      $display("wav_chunk_stream_parser_core_test NOT OK");
    $finish;
  end

endmodule

[wav_chunk_stream_parser_core.f]
hw/rtl/wcsp_pkg.sv
hw/rtl/wcsp_div.sv
hw/rtl/wav_chunk_stream_parser_core.sv
tb/sv/wav_chunk_stream_parser_core_test.sv
